/* rtl/linked_stack_pool_with_splice_defines.svh */
// Assertion macros shared by the block's checking code.
// Each macro expects clk and arst_n to be visible where it is used.
`ifndef LINKED_STACK_POOL_WITH_SPLICE_DEFINES_SVH
`define LINKED_STACK_POOL_WITH_SPLICE_DEFINES_SVH

// Same-cycle implication, off while reset is active.
`define LSP_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, off while reset is active.
`define LSP_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/lsp_pkg.sv */
package lsp_pkg;

	// Default sizes of the pool and the stack table
	localparam int POOL_DEPTH_DEF  = 1024;
	localparam int NUM_STACKS_DEF  = 256;
	localparam int VALUE_WIDTH_DEF = 32;

	// Field widths of the request and response channels
	localparam int TYPE_W      = 2;
	localparam int STACK_ID_W  = 8;
	localparam int NODE_IDX_W  = 10;
	localparam int PUSH_VAL_W  = 32;
	localparam int STACK_CNT_W = 11;
	localparam int TOP_NODE_W  = 10;

	// Request codes
	localparam logic [TYPE_W-1:0] REQ_PUSH  = 2'd0;
	localparam logic [TYPE_W-1:0] REQ_MOVE  = 2'd1;
	localparam logic [TYPE_W-1:0] REQ_QUERY = 2'd2;
	localparam logic [TYPE_W-1:0] REQ_READ  = 2'd3;

	// Response status codes
	localparam logic STATUS_OK   = 1'b0;
	localparam logic STATUS_FULL = 1'b1;

	// Controller to datapath
	typedef struct packed {
		logic clr_wr;  // clearing pass: zero one stack record
		logic take;    // capture the request
		logic rd;      // read stack records and node
		logic exec;    // commit updates and load the response
		logic src_wr;  // empty the source stack of a move
	} lsp_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic clr_last;   // clearing pass at its last record
		logic out_free;   // response register can take a new response
		logic move_live;  // current move changes state and needs a source clear
	} lsp_sts_t;

endpackage

/* rtl/lsp_if.sv */
interface lsp_req_if;
	logic                               valid;
	logic                               ready;
	logic [lsp_pkg::TYPE_W-1:0]         req_type;
	logic [lsp_pkg::STACK_ID_W-1:0]     stack_id;
	logic [lsp_pkg::STACK_ID_W-1:0]     source_stack;
	logic signed [lsp_pkg::PUSH_VAL_W-1:0] push_value;
	logic [lsp_pkg::NODE_IDX_W-1:0]     node_index;

	modport source (output valid, req_type, stack_id, source_stack, push_value, node_index,
		input ready);
	modport sink (input valid, req_type, stack_id, source_stack, push_value, node_index,
		output ready);
endinterface

interface lsp_rsp_if;
	logic                               valid;
	logic                               ready;
	logic                               status;
	logic [lsp_pkg::STACK_CNT_W-1:0]    stack_count;
	logic [lsp_pkg::TOP_NODE_W-1:0]     top_node;
	logic signed [lsp_pkg::PUSH_VAL_W-1:0] node_value;
	logic [lsp_pkg::NODE_IDX_W-1:0]     next_node;
	logic                               has_next;

	modport source (output valid, status, stack_count, top_node, node_value, next_node,
		has_next, input ready);
	modport sink (input valid, status, stack_count, top_node, node_value, next_node,
		has_next, output ready);
endinterface

/* rtl/linked_stack_pool_with_splice.sv */
// Linked stack pool with splice: NUM_STACKS stacks share one pool of POOL_DEPTH
// nodes, each node holding a VALUE_WIDTH-bit value and a link to the node below.
// Nodes are handed out in order and never freed. Every request on req gives
// exactly one response on rsp: push takes the next free node (status FULL and
// no change once the pool is used up), move splices the whole source stack onto
// the destination in one step and empties the source (a move onto itself or
// from an empty stack changes nothing), query returns count and top node, and
// read returns a node's value and link. Stack and node numbers wrap modulo the
// table sizes. Reading a node that no push wrote gives an undefined value and
// link. After reset the block sweeps the stack table clear with req.ready low.
// Each request then passes through capture, memory read, and update and
// response; the update waits while a response still sits unaccepted on rsp,
// and a move that changes state adds a second write to the single-port stack
// table to empty the source. The response sits in an output register, so the
// next request is taken while a response waits on rsp.ready.
`include "linked_stack_pool_with_splice_defines.svh"

module linked_stack_pool_with_splice #(
	parameter int POOL_DEPTH  = lsp_pkg::POOL_DEPTH_DEF,
	parameter int NUM_STACKS  = lsp_pkg::NUM_STACKS_DEF,
	parameter int VALUE_WIDTH = lsp_pkg::VALUE_WIDTH_DEF
) (
	input logic       clk,
	input logic       arst_n,
	lsp_req_if.sink   req,
	lsp_rsp_if.source rsp
);

	lsp_pkg::lsp_cmd_t cmd;
	lsp_pkg::lsp_sts_t sts;

	// Sequencer: clearing pass, then capture, read, update and, for a live move, source clear per request
	lsp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (req.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// Stack table, node pool, allocation counter and response register
	lsp_dp #(
		.POOL_DEPTH  (POOL_DEPTH),
		.NUM_STACKS  (NUM_STACKS),
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.req_type     (req.req_type),
		.stack_id     (req.stack_id),
		.source_stack (req.source_stack),
		.push_value   (req.push_value),
		.node_index   (req.node_index),
		.out_ready    (rsp.ready),
		.out_valid    (rsp.valid),
		.status       (rsp.status),
		.stack_count  (rsp.stack_count),
		.top_node     (rsp.top_node),
		.node_value   (rsp.node_value),
		.next_node    (rsp.next_node),
		.has_next     (rsp.has_next)
	);

	// An accepted request goes straight to its memory read
	`LSP_ASSERT_NEXT(a_take_then_read, req.valid && req.ready, cmd.rd, "request not read")
	// No request is taken while the stack table is being cleared
	`LSP_ASSERT_IMPL(a_no_take_in_clear, cmd.clr_wr, !req.ready, "request during clear")
	// A committed request always shows its response next cycle
	`LSP_ASSERT_NEXT(a_exec_then_rsp, cmd.exec, rsp.valid, "response lost")
	// After the source clear of a move, the block takes requests again
	`LSP_ASSERT_NEXT(a_fix_then_idle, cmd.src_wr, req.ready, "stuck after move")

endmodule

/* rtl/lsp_ctrl.sv */
module lsp_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  lsp_pkg::lsp_sts_t sts,
	output lsp_pkg::lsp_cmd_t cmd
);

	localparam logic [2:0] ST_CLR  = 3'd0;
	localparam logic [2:0] ST_IDLE = 3'd1;
	localparam logic [2:0] ST_RD   = 3'd2;
	localparam logic [2:0] ST_EX   = 3'd3;
	localparam logic [2:0] ST_FIX  = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_nxt;

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_CLR: begin
				if (sts.clr_last) state_nxt = ST_IDLE;
			end
			ST_IDLE: begin
				if (in_valid) state_nxt = ST_RD;
			end
			ST_RD: begin
				state_nxt = ST_EX;
			end
			ST_EX: begin
				if (sts.out_free) state_nxt = sts.move_live ? ST_FIX : ST_IDLE;
			end
			ST_FIX: begin
				state_nxt = ST_IDLE;
			end
			default: begin
				state_nxt = ST_CLR;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLR;
		end else begin
			state_q <= state_nxt;
		end
	end

	assign in_ready   = (state_q == ST_IDLE);
	assign cmd.clr_wr = (state_q == ST_CLR);
	assign cmd.take   = (state_q == ST_IDLE) && in_valid;
	assign cmd.rd     = (state_q == ST_RD);
	assign cmd.exec   = (state_q == ST_EX) && sts.out_free;
	assign cmd.src_wr = (state_q == ST_FIX);

endmodule

/* rtl/lsp_dp.sv */
module lsp_dp #(
	parameter int POOL_DEPTH  = lsp_pkg::POOL_DEPTH_DEF,
	parameter int NUM_STACKS  = lsp_pkg::NUM_STACKS_DEF,
	parameter int VALUE_WIDTH = lsp_pkg::VALUE_WIDTH_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  lsp_pkg::lsp_cmd_t                     cmd,
	output lsp_pkg::lsp_sts_t                     sts,
	input  logic [lsp_pkg::TYPE_W-1:0]            req_type,
	input  logic [lsp_pkg::STACK_ID_W-1:0]        stack_id,
	input  logic [lsp_pkg::STACK_ID_W-1:0]        source_stack,
	input  logic signed [lsp_pkg::PUSH_VAL_W-1:0] push_value,
	input  logic [lsp_pkg::NODE_IDX_W-1:0]        node_index,
	input  logic                                  out_ready,
	output logic                                  out_valid,
	output logic                                  status,
	output logic [lsp_pkg::STACK_CNT_W-1:0]       stack_count,
	output logic [lsp_pkg::TOP_NODE_W-1:0]        top_node,
	output logic signed [lsp_pkg::PUSH_VAL_W-1:0] node_value,
	output logic [lsp_pkg::NODE_IDX_W-1:0]        next_node,
	output logic                                  has_next
);

	localparam int PW    = $clog2(POOL_DEPTH);
	localparam int SW    = $clog2(NUM_STACKS);
	localparam int CW    = $clog2(POOL_DEPTH + 1);
	localparam int VW    = VALUE_WIDTH;
	localparam int LW    = PW + 1;
	localparam int REC_W = CW + 2 * PW;
	localparam int TW    = lsp_pkg::TYPE_W;
	localparam int IDW   = lsp_pkg::STACK_ID_W;
	localparam int NIW   = lsp_pkg::NODE_IDX_W;
	localparam int OVW   = lsp_pkg::PUSH_VAL_W;
	localparam int OCW   = lsp_pkg::STACK_CNT_W;
	localparam int OTW   = lsp_pkg::TOP_NODE_W;
	// Reciprocal for node_index mod POOL_DEPTH, exact for any NIW-bit index
	localparam int RSH   = NIW + $clog2(POOL_DEPTH);
	localparam int RW    = NIW + 2;
	localparam int PRW   = NIW + RW;
	localparam logic [RW-1:0] RCP = RW'((2 ** RSH + POOL_DEPTH - 1) / POOL_DEPTH);

	// Stack number wrap table
	logic [SW-1:0] stk_map [2 ** IDW];
	for (genvar g = 0; g < 2 ** IDW; g++) begin : g_map
		assign stk_map[g] = SW'(g % NUM_STACKS);
	end

	// Memories
	logic [REC_W-1:0] stk_mem [NUM_STACKS];
	logic [VW-1:0]    val_mem [POOL_DEPTH];
	logic [LW-1:0]    lnk_mem [POOL_DEPTH];

	// Request registers
	logic [TW-1:0]  type_q;
	logic [SW-1:0]  dst_q;
	logic [SW-1:0]  src_q;
	logic [VW-1:0]  pval_q;
	logic [NIW-1:0] nidx_q;
	logic [NIW-1:0] nq_q;

	// Read data
	logic [REC_W-1:0] dst_rec_q;
	logic [REC_W-1:0] src_rec_q;
	logic [VW-1:0]    val_rd_q;
	logic [LW-1:0]    lnk_rd_q;

	logic [CW-1:0] used_q;
	logic [SW-1:0] sweep_q;
	logic          out_valid_q;

	logic [PRW-1:0] nprod;
	logic [NIW-1:0] nquo;
	logic [NIW-1:0] nrem;
	logic [PW-1:0]  naddr;

	logic [CW-1:0] dcnt, scnt;
	logic [PW-1:0] dtop, dbot, stop, sbot;
	logic          is_push, is_move, is_query, is_read;
	logic          full, push_ok, move_live;
	logic [PW-1:0] new_node;

	logic             stk_we;
	logic [SW-1:0]    stk_wa;
	logic [REC_W-1:0] stk_wd;
	logic             lnk_we;
	logic [PW-1:0]    lnk_wa;
	logic [LW-1:0]    lnk_wd;

	// Quotient of the node index, registered before the multiply-back
	assign nprod = {{RW{1'b0}}, node_index} * {{NIW{1'b0}}, RCP};
	assign nquo  = NIW'(nprod >> RSH);
	assign nrem  = nidx_q - NIW'(nq_q * POOL_DEPTH);
	assign naddr = PW'(nrem);

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			type_q <= req_type;
			dst_q  <= stk_map[stack_id];
			src_q  <= stk_map[source_stack];
			pval_q <= VW'(push_value);
			nidx_q <= node_index;
			nq_q   <= nquo;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rd) begin
			dst_rec_q <= stk_mem[dst_q];
			src_rec_q <= stk_mem[src_q];
			val_rd_q  <= val_mem[naddr];
			lnk_rd_q  <= lnk_mem[naddr];
		end
	end

	assign dcnt = dst_rec_q[REC_W-1 -: CW];
	assign dtop = dst_rec_q[2*PW-1 -: PW];
	assign dbot = dst_rec_q[PW-1:0];
	assign scnt = src_rec_q[REC_W-1 -: CW];
	assign stop = src_rec_q[2*PW-1 -: PW];
	assign sbot = src_rec_q[PW-1:0];

	assign is_push   = (type_q == lsp_pkg::REQ_PUSH);
	assign is_move   = (type_q == lsp_pkg::REQ_MOVE);
	assign is_query  = (type_q == lsp_pkg::REQ_QUERY);
	assign is_read   = (type_q == lsp_pkg::REQ_READ);
	assign full      = (used_q == CW'(POOL_DEPTH));
	assign push_ok   = is_push && !full;
	assign move_live = is_move && (src_q != dst_q) && (scnt != '0);
	assign new_node  = PW'(used_q);

	always_comb begin
		stk_we = 1'b0;
		stk_wa = dst_q;
		stk_wd = '0;
		if (cmd.clr_wr) begin
			stk_we = 1'b1;
			stk_wa = sweep_q;
		end else if (cmd.src_wr) begin
			stk_we = 1'b1;
			stk_wa = src_q;
		end else if (cmd.exec && push_ok) begin
			stk_we = 1'b1;
			stk_wd = {dcnt + 1'b1, new_node, (dcnt == '0) ? new_node : dbot};
		end else if (cmd.exec && move_live) begin
			stk_we = 1'b1;
			stk_wd = {dcnt + scnt, stop, (dcnt == '0) ? sbot : dbot};
		end
	end

	always_comb begin
		lnk_we = 1'b0;
		lnk_wa = new_node;
		lnk_wd = {1'b1, dtop};
		if (cmd.exec && push_ok) begin
			lnk_we = 1'b1;
			if (dcnt == '0) lnk_wd = '0;
		end else if (cmd.exec && move_live && (dcnt != '0)) begin
			// hang the old destination top below the source bottom
			lnk_we = 1'b1;
			lnk_wa = sbot;
		end
	end

	always_ff @(posedge clk) begin
		if (stk_we) stk_mem[stk_wa] <= stk_wd;
		if (lnk_we) lnk_mem[lnk_wa] <= lnk_wd;
		if (cmd.exec && push_ok) val_mem[new_node] <= pval_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q      <= '0;
			sweep_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.exec && push_ok) used_q <= used_q + 1'b1;
			if (cmd.clr_wr) sweep_q <= sweep_q + 1'b1;
			if (cmd.exec) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			status      <= (is_push && full) ? lsp_pkg::STATUS_FULL : lsp_pkg::STATUS_OK;
			stack_count <= is_query ? OCW'(dcnt) : '0;
			top_node    <= (is_query && (dcnt != '0)) ? OTW'(dtop) : '0;
			node_value  <= is_read ? OVW'($signed(val_rd_q)) : '0;
			next_node   <= (is_read && lnk_rd_q[PW]) ? NIW'(lnk_rd_q[PW-1:0]) : '0;
			has_next    <= is_read && lnk_rd_q[PW];
		end
	end

	assign out_valid     = out_valid_q;
	assign sts.clr_last  = (sweep_q == SW'(NUM_STACKS - 1));
	assign sts.out_free  = !out_valid_q || out_ready;
	assign sts.move_live = move_live;

endmodule
